// ----- design/bpse_pkg.sv -----
// ----------------------------------------------------------------------------
// bpse_pkg
// shared types and constants of the battery power status evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpse_pkg;

    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 2;

    // lipo curve, highest point first
    localparam int CURVE_POINTS = 11;
    localparam int SEG_W        = 4;

    localparam logic [MV_W-1:0] CURVE_MV [0:CURVE_POINTS-1] = '{
        16'd4200, 16'd4110, 16'd4030, 16'd3980, 16'd3920, 16'd3870,
        16'd3820, 16'd3790, 16'd3740, 16'd3680, 16'd3300
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [0:CURVE_POINTS-1] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };
    // every segment of the curve spans ten percent
    localparam int PCT_STEP = 10;

    // curve interpolation widths
    localparam int CURVE_SPAN_W   = 9;   // widest segment is 380 mV
    localparam int CURVE_SCALED_W = 12;  // span times ten stays below 4096
    localparam int CURVE_FRAC_W   = 4;

    localparam logic [MV_W-1:0] RST_USB_THRESHOLD_MV = 16'd4000;
    localparam logic [MV_W-1:0] RST_BATTERY_MIN_MV   = 16'd2500;
    localparam logic [MV_W-1:0] RST_BATTERY_MAX_MV   = 16'd4500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USB_THRESHOLD = 2'd0,
        CFG_BATTERY_MIN   = 2'd1,
        CFG_BATTERY_MAX   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_READ = 2'd1,
        STATUS_BAD_CFG = 2'd2
    } status_t;

    typedef struct packed {
        logic [MV_W-1:0] usb_threshold_mv;
        logic [MV_W-1:0] battery_min_mv;
        logic [MV_W-1:0] battery_max_mv;
    } cfg_t;

    // first field in the highest bits
    typedef struct packed {
        logic            charge_read_ok;
        logic            charge_flag;
        logic            rail5_read_ok;
        logic [MV_W-1:0] rail5_mv;
        logic            input_read_ok;
        logic [MV_W-1:0] input_mv;
        logic            battery_read_ok;
        logic [MV_W-1:0] battery_mv;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic             usb_good;
        logic             usb_detect;
        logic             charging;
        logic [PCT_W-1:0] charge_pct;
        logic             battery_valid;
        logic [MV_W-1:0]  rail5_mv_out;
        logic [MV_W-1:0]  input_mv_out;
        logic [MV_W-1:0]  battery_mv_out;
    } result_t;

    localparam int IN_ITEM_W  = $bits(in_item_t);
    localparam int RESULT_W   = $bits(result_t);
    localparam int IN_TDATA_W  = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- design/bpse_cfg.sv -----
// ----------------------------------------------------------------------------
// bpse_cfg
// configuration registers: usb threshold and battery window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpse_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bpse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpse_pkg::MV_W-1:0]        cfg_wdata,
    output bpse_pkg::cfg_t                   cfg
);

    bpse_pkg::cfg_t cfg_reg;
    bpse_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bpse_pkg::CFG_USB_THRESHOLD: cfg_next.usb_threshold_mv = cfg_wdata;
                bpse_pkg::CFG_BATTERY_MIN:   cfg_next.battery_min_mv   = cfg_wdata;
                bpse_pkg::CFG_BATTERY_MAX:   cfg_next.battery_max_mv   = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.usb_threshold_mv <= bpse_pkg::RST_USB_THRESHOLD_MV;
            cfg_reg.battery_min_mv   <= bpse_pkg::RST_BATTERY_MIN_MV;
            cfg_reg.battery_max_mv   <= bpse_pkg::RST_BATTERY_MAX_MV;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/bpse_curve.sv -----
// ----------------------------------------------------------------------------
// bpse_curve
// lipo millivolts to percent by truncating piecewise-linear lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpse_curve
(
    input  logic [bpse_pkg::MV_W-1:0]  mv,
    output logic [bpse_pkg::PCT_W-1:0] pct
);

    logic                                  at_top;
    logic                                  in_seg;
    logic [bpse_pkg::SEG_W-1:0]            seg;
    logic [bpse_pkg::MV_W-1:0]             upper_mv;
    logic [bpse_pkg::MV_W-1:0]             lower_mv;
    logic [bpse_pkg::MV_W-1:0]             span_full;
    logic [bpse_pkg::MV_W-1:0]             diff_full;
    logic [bpse_pkg::CURVE_SPAN_W-1:0]     span;
    logic [bpse_pkg::CURVE_SPAN_W-1:0]     diff;
    logic [bpse_pkg::CURVE_SCALED_W-1:0]   scaled;
    logic [bpse_pkg::CURVE_SCALED_W-1:0]   thr;
    logic [bpse_pkg::CURVE_FRAC_W-1:0]     frac;

    // segment search: smallest point index at or below mv
    always_comb
    begin
        at_top = (mv >= bpse_pkg::CURVE_MV[0]);
        in_seg = 1'b0;
        seg    = bpse_pkg::SEG_W'(1);
        for (int k = bpse_pkg::CURVE_POINTS - 1; k >= 1; k--)
        begin
            if (mv >= bpse_pkg::CURVE_MV[k])
            begin
                in_seg = 1'b1;
                seg    = bpse_pkg::SEG_W'(k);
            end
        end
    end

    // offset in segment scaled by the percent step, then compared to span multiples
    always_comb
    begin
        upper_mv  = bpse_pkg::CURVE_MV[seg - bpse_pkg::SEG_W'(1)];
        lower_mv  = bpse_pkg::CURVE_MV[seg];
        span_full = upper_mv - lower_mv;
        diff_full = mv - lower_mv;
        span      = span_full[bpse_pkg::CURVE_SPAN_W-1:0];
        diff      = diff_full[bpse_pkg::CURVE_SPAN_W-1:0];
        scaled    = bpse_pkg::CURVE_SCALED_W'(diff)
                    * bpse_pkg::CURVE_SCALED_W'(bpse_pkg::PCT_STEP);
        frac      = '0;
        thr       = '0;
        for (int j = 1; j < bpse_pkg::PCT_STEP; j++)
        begin
            thr = bpse_pkg::CURVE_SCALED_W'(span) * bpse_pkg::CURVE_SCALED_W'(j);
            if (scaled >= thr)
            begin
                frac = bpse_pkg::CURVE_FRAC_W'(j);
            end
        end
    end

    always_comb
    begin
        if (at_top)
        begin
            pct = bpse_pkg::CURVE_PCT[0];
        end
        else if (in_seg)
        begin
            pct = bpse_pkg::CURVE_PCT[seg] + bpse_pkg::PCT_W'(frac);
        end
        else
        begin
            pct = '0;
        end
    end

endmodule

// ----- design/bpse_eval.sv -----
// ----------------------------------------------------------------------------
// bpse_eval
// evaluation of one sample set against the configuration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpse_eval
(
    input  bpse_pkg::cfg_t     cfg,
    input  bpse_pkg::in_item_t item,
    output bpse_pkg::result_t  res
);

    logic                          bad_cfg;
    logic                          bat_valid;
    logic                          present;
    logic [bpse_pkg::PCT_W-1:0]    curve_pct;

    bpse_curve u_curve
    (
        .mv  (item.battery_mv),
        .pct (curve_pct)
    );

    always_comb
    begin
        bad_cfg   = (cfg.battery_min_mv > cfg.battery_max_mv);
        bat_valid = item.battery_read_ok
                    && (item.battery_mv >= cfg.battery_min_mv)
                    && (item.battery_mv <= cfg.battery_max_mv);
        present   = (item.input_read_ok && (item.input_mv >= cfg.usb_threshold_mv))
                    || (item.rail5_read_ok && (item.rail5_mv >= cfg.usb_threshold_mv));

        res.battery_mv_out  = item.battery_read_ok ? item.battery_mv : '0;
        res.input_mv_out    = item.input_read_ok   ? item.input_mv   : '0;
        res.rail5_mv_out    = item.rail5_read_ok   ? item.rail5_mv   : '0;
        res.battery_valid   = bat_valid;
        res.charge_pct      = bat_valid ? curve_pct : '0;
        res.charging        = item.charge_read_ok && item.charge_flag;
        res.usb_detect      = present;
        res.usb_good        = present || (item.input_read_ok && item.rail5_read_ok);
        if (item.battery_read_ok || item.input_read_ok || item.rail5_read_ok)
        begin
            res.status = bpse_pkg::STATUS_OK;
        end
        else
        begin
            res.status = bpse_pkg::STATUS_NO_READ;
        end

        // bad window overrides everything
        if (bad_cfg)
        begin
            res        = '0;
            res.status = bpse_pkg::STATUS_BAD_CFG;
        end
    end

endmodule

// ----- design/battery_power_status_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// battery_power_status_evaluator_top
// battery, input rail and 5v rail status with lipo charge percent
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------
//  s_*      | in  | s_tvalid / s_tready | s_tdata: one sample set (56 bits)
//  m_*      | out | m_tvalid / m_tready | m_tdata: one status result (64 bits)
//  cfg_*    | in  | cfg_we              | cfg_index, cfg_wdata: threshold, window
//
//  one item per clock sustained while m_tready holds; each item passes the input
//  register and then the result register, with the curve lookup and limit compares between them
//  reset clears both valid flags and loads the default threshold and window
//  a stalled result holds in the result register while the input register
//  still takes one more item; s_tready drops only when both are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_power_status_evaluator_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // battery_mv[15:0], battery_read_ok[16], input_mv[32:17], input_read_ok[33],
    // rail5_mv[49:34], rail5_read_ok[50], charge_flag[51], charge_read_ok[52],
    // zero pad[55:53]
    input  logic [bpse_pkg::IN_TDATA_W-1:0]       s_tdata,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // battery_mv_out[15:0], input_mv_out[31:16], rail5_mv_out[47:32],
    // battery_valid[48], charge_pct[55:49], charging[56], usb_detect[57],
    // usb_good[58], status[60:59], zero pad[63:61]
    output logic [bpse_pkg::OUT_TDATA_W-1:0]      m_tdata,

    input  logic                                  cfg_we,
    input  logic [bpse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpse_pkg::MV_W-1:0]             cfg_wdata
);

    bpse_pkg::cfg_t      cfg;

    // input register
    logic                s1_valid_reg;
    logic                s1_valid_next;
    bpse_pkg::in_item_t  s1_item_reg;

    // result register
    logic                m_valid_reg;
    logic                m_valid_next;
    bpse_pkg::result_t   m_res_reg;
    bpse_pkg::result_t   eval_res;

    logic                s1_ready;
    logic                s2_ready;
    logic                s_take;
    logic                s1_move;

    bpse_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpse_eval u_eval
    (
        .cfg  (cfg),
        .item (s1_item_reg),
        .res  (eval_res)
    );

    // a stage can load when empty or when its item leaves this cycle
    assign s2_ready = !m_valid_reg || m_tready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_take   = s_tvalid && s1_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = s_tvalid;
        end

        m_valid_next = m_valid_reg;
        if (s2_ready)
        begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            s1_item_reg <= s_tdata[bpse_pkg::IN_ITEM_W-1:0];
        end
        if (s1_move)
        begin
            m_res_reg <= eval_res;
        end
    end

    assign s_tready = s1_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(bpse_pkg::OUT_TDATA_W - bpse_pkg::RESULT_W){1'b0}}, m_res_reg};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // bad window result carries nothing but its status
    a_bad_cfg_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_res_reg.status == bpse_pkg::STATUS_BAD_CFG))
        |-> (m_res_reg.battery_mv_out == '0) && (m_res_reg.input_mv_out == '0)
            && (m_res_reg.rail5_mv_out == '0) && !m_res_reg.charging
            && !m_res_reg.usb_good)
        else $error("bad configuration result has nonzero fields");

    // percent stays on the curve and is zero for an invalid battery
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_res_reg.charge_pct <= 7'd100)
            && (m_res_reg.battery_valid || (m_res_reg.charge_pct == '0)))
        else $error("battery percent out of range");

    // usb detected always implies usb good
    a_usb: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_res_reg.usb_detect) |-> m_res_reg.usb_good)
        else $error("usb detected without usb good");

    // an item in the input register is never dropped while the output stalls
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("input register lost its item during a stall");

    // a result is written only from an occupied input register
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_valid_reg && !s1_valid_reg) |=> !m_valid_reg)
        else $error("result appeared with no item in flight");

endmodule

// ----- verif/battery_power_status_evaluator_top_tb.sv -----
// ----------------------------------------------------------------------------
// battery_power_status_evaluator_top_tb
// drives sample sets through the stream input and compares each status result
// with a local model of the rails, the battery window and the lipo curve. it
// rewrites the threshold and window registers between traffic phases, and it
// runs the receiver and the sender with and without random gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_power_status_evaluator_top_tb;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    // input register plus result register
    localparam int PIPE_LAT       = 2;
    localparam int SETTLE_CYCLES  = PIPE_LAT + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 425;
    localparam int DRAIN_EVERY    = 150;
    localparam int READ_OK_PCT    = 85;

    // index past the last register, writes to it must be dropped
    localparam logic [bpse_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [bpse_pkg::MV_W-1:0]      MV_MAX         = 16'hFFFF;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [bpse_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [bpse_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_we;
    logic [bpse_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [bpse_pkg::MV_W-1:0]        cfg_wdata;

    // local copy of the register file
    logic [bpse_pkg::MV_W-1:0] thr_mv;
    logic [bpse_pkg::MV_W-1:0] win_min_mv;
    logic [bpse_pkg::MV_W-1:0] win_max_mv;

    // results predicted for accepted items, oldest first
    bpse_pkg::result_t pending_status_q [$];

    int mismatch_cnt;
    int send_idle_pct;
    int recv_stall_pct;

    battery_power_status_evaluator_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------------

    // knee points of the lipo curve, highest first, ten percent apart
    function automatic int knee_mv(input int k);
        case (k)
            0:       return 4200;
            1:       return 4110;
            2:       return 4030;
            3:       return 3980;
            4:       return 3920;
            5:       return 3870;
            6:       return 3820;
            7:       return 3790;
            8:       return 3740;
            9:       return 3680;
            10:      return 3300;
            default: return 0;
        endcase
    endfunction

    function automatic int knee_pct(input int k);
        return 100 - 10 * k;
    endfunction

    // truncating interpolation between knees, clamped at both ends
    function automatic logic [bpse_pkg::PCT_W-1:0] lipo_percent(
        input logic [bpse_pkg::MV_W-1:0] mv);
        int v;
        int k;
        v = int'(mv);
        if (v >= knee_mv(0))
            return bpse_pkg::PCT_W'(knee_pct(0));
        for (k = 1; k < bpse_pkg::CURVE_POINTS; k++)
        begin
            if (v >= knee_mv(k))
                return bpse_pkg::PCT_W'(knee_pct(k)
                    + ((v - knee_mv(k)) * (knee_pct(k - 1) - knee_pct(k)))
                      / (knee_mv(k - 1) - knee_mv(k)));
        end
        return '0;
    endfunction

    function automatic bpse_pkg::result_t predict_status(input bpse_pkg::in_item_t s);
        bpse_pkg::result_t r;
        r = '0;
        // inverted window zeroes everything but the status
        if (win_min_mv > win_max_mv)
        begin
            r.status = bpse_pkg::STATUS_BAD_CFG;
            return r;
        end
        r.battery_mv_out  = s.battery_read_ok ? s.battery_mv : '0;
        r.input_mv_out    = s.input_read_ok ? s.input_mv : '0;
        r.rail5_mv_out    = s.rail5_read_ok ? s.rail5_mv : '0;
        r.battery_valid   = s.battery_read_ok && s.battery_mv >= win_min_mv
                            && s.battery_mv <= win_max_mv;
        r.charge_pct      = r.battery_valid ? lipo_percent(s.battery_mv) : '0;
        r.charging        = s.charge_read_ok && s.charge_flag;
        r.usb_detect      = (s.input_read_ok && s.input_mv >= thr_mv)
                            || (s.rail5_read_ok && s.rail5_mv >= thr_mv);
        r.usb_good        = r.usb_detect || (s.input_read_ok && s.rail5_read_ok);
        r.status          = (s.battery_read_ok || s.input_read_ok || s.rail5_read_ok)
                            ? bpse_pkg::STATUS_OK : bpse_pkg::STATUS_NO_READ;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic bit same_result(input bpse_pkg::result_t a,
                                       input bpse_pkg::result_t b);
        return a.battery_mv_out === b.battery_mv_out
            && a.input_mv_out === b.input_mv_out
            && a.rail5_mv_out === b.rail5_mv_out
            && a.battery_valid === b.battery_valid
            && a.charge_pct === b.charge_pct
            && a.charging === b.charging
            && a.usb_detect === b.usb_detect
            && a.usb_good === b.usb_good
            && a.status === b.status;
    endfunction

    function automatic string fmt_result(input bpse_pkg::result_t r);
        return $sformatf({"bat %0d in %0d r5 %0d valid %0d pct %0d chg %0d",
                          " detect %0d usb %0d st %0d"},
                         r.battery_mv_out, r.input_mv_out, r.rail5_mv_out, r.battery_valid,
                         r.charge_pct, r.charging, r.usb_detect, r.usb_good, r.status);
    endfunction

    task automatic check_result(input bpse_pkg::result_t got);
        bpse_pkg::result_t want;
        if (pending_status_q.size() == 0)
        begin
            if (mismatch_cnt < MAX_REPORTS)
                $display("%0t: result with nothing pending: %s", $time, fmt_result(got));
            mismatch_cnt++;
        end
        else
        begin
            want = pending_status_q.pop_front();
            if (!same_result(want, got))
            begin
                if (mismatch_cnt < MAX_REPORTS)
                begin
                    $display("%0t: mismatch expected %s", $time, fmt_result(want));
                    $display("%0t: mismatch actual   %s", $time, fmt_result(got));
                end
                mismatch_cnt++;
            end
        end
    endtask

    // outputs are sampled at the rising edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(bpse_pkg::result_t'(m_tdata[bpse_pkg::RESULT_W-1:0]));
    end

    // receiver backpressure, changed at the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ends the run when no item moves on either side for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("battery_power_status_evaluator_top_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // sender side: valid only ever changes at the falling edge, once per edge
    task automatic send_item(input bpse_pkg::in_item_t sample);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bpse_pkg::IN_TDATA_W'(sample);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_status_q.push_back(predict_status(sample));
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bpse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpse_pkg::MV_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bpse_pkg::CFG_USB_THRESHOLD: thr_mv = value;
            bpse_pkg::CFG_BATTERY_MIN:   win_min_mv = value;
            bpse_pkg::CFG_BATTERY_MAX:   win_max_mv = value;
            default: ;
        endcase
    endtask

    // registers only change once the pipeline is empty
    task automatic apply_settings(input logic [bpse_pkg::MV_W-1:0] thr,
                                  input logic [bpse_pkg::MV_W-1:0] lo,
                                  input logic [bpse_pkg::MV_W-1:0] hi);
        drain_results();
        write_reg(bpse_pkg::CFG_USB_THRESHOLD, thr);
        write_reg(bpse_pkg::CFG_BATTERY_MIN, lo);
        write_reg(bpse_pkg::CFG_BATTERY_MAX, hi);
    endtask

    function automatic bpse_pkg::in_item_t make_sample(
        input logic [bpse_pkg::MV_W-1:0] bat, input logic bat_ok,
        input logic [bpse_pkg::MV_W-1:0] vin, input logic vin_ok,
        input logic [bpse_pkg::MV_W-1:0] r5, input logic r5_ok,
        input logic chg, input logic chg_ok);
        bpse_pkg::in_item_t s;
        s.battery_mv      = bat;
        s.battery_read_ok = bat_ok;
        s.input_mv        = vin;
        s.input_read_ok   = vin_ok;
        s.rail5_mv        = r5;
        s.rail5_read_ok   = r5_ok;
        s.charge_flag     = chg;
        s.charge_read_ok  = chg_ok;
        return s;
    endfunction

    // mostly the curve range, some full range, some hugging a compare point
    function automatic logic [bpse_pkg::MV_W-1:0] rand_mv(
        input logic [bpse_pkg::MV_W-1:0] focus);
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, 65535);
            2:       v = $urandom_range(0, 1) ? 65535 : 0;
            3, 4:    v = int'(focus) + int'($urandom_range(0, 6)) - 3;
            default: v = $urandom_range(3250, 4300);
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return bpse_pkg::MV_W'(v);
    endfunction

    function automatic logic read_ok_roll();
        return $urandom_range(0, 99) < READ_OK_PCT;
    endfunction

    function automatic bpse_pkg::in_item_t rand_sample();
        logic [bpse_pkg::MV_W-1:0] bat_focus;
        bat_focus = $urandom_range(0, 1) ? win_min_mv : win_max_mv;
        return make_sample(rand_mv(bat_focus), read_ok_roll(),
                           rand_mv(thr_mv), read_ok_roll(),
                           rand_mv(thr_mv), read_ok_roll(),
                           1'($urandom_range(0, 1)), read_ok_roll());
    endfunction

    task automatic randomize_settings();
        logic [bpse_pkg::MV_W-1:0] thr;
        logic [bpse_pkg::MV_W-1:0] lo;
        logic [bpse_pkg::MV_W-1:0] hi;
        logic [bpse_pkg::MV_W-1:0] tmp;
        case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = MV_MAX;
            default: thr = bpse_pkg::MV_W'($urandom_range(3500, 5500));
        endcase
        case ($urandom_range(0, 7))
            0:
            begin
                lo = '0;
                hi = MV_MAX;
            end
            1:
            begin
                // single-voltage window
                lo = bpse_pkg::MV_W'($urandom_range(3300, 4200));
                hi = lo;
            end
            2:
            begin
                lo = bpse_pkg::MV_W'($urandom_range(0, 65535));
                hi = bpse_pkg::MV_W'($urandom_range(0, 65535));
                if (lo > hi)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            default:
            begin
                lo = bpse_pkg::MV_W'($urandom_range(2000, 3700));
                hi = bpse_pkg::MV_W'($urandom_range(3800, 4700));
            end
        endcase
        apply_settings(thr, lo, hi);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset window 2500..4500, threshold 4000
    task automatic test_default_curve();
        int k;
        // nothing read, charge still reported
        send_item(make_sample(16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1));
        // every knee of the curve, input rail exactly at threshold
        for (k = 0; k < bpse_pkg::CURVE_POINTS; k++)
            send_item(make_sample(bpse_pkg::MV_W'(knee_mv(k)), 1'b1, 16'd4000, 1'b1,
                                  16'd3999, 1'b1, 1'b1, k[0]));
        // just under the top knee, both rails just under threshold
        send_item(make_sample(16'd4199, 1'b1, 16'd3999, 1'b1, 16'd3999, 1'b1, 1'b0, 1'b1));
        // below the bottom knee, only one rail read
        send_item(make_sample(16'd3299, 1'b1, 16'd3999, 1'b0, 16'd3999, 1'b1, 1'b1, 1'b0));
        // window edges
        send_item(make_sample(16'd2499, 1'b1, 16'd0, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_sample(16'd2500, 1'b1, 16'd0, 1'b0, 16'd0, 1'b1, 1'b0, 1'b0));
        send_item(make_sample(16'd4500, 1'b1, 16'd4001, 1'b0, 16'd4001, 1'b1, 1'b0, 1'b0));
        send_item(make_sample(16'd4501, 1'b1, 16'd4001, 1'b1, 16'd0, 1'b0, 1'b1, 1'b1));
        // all ones, with the input read failing
        send_item(make_sample(MV_MAX, 1'b1, MV_MAX, 1'b0, MV_MAX, 1'b1, 1'b1, 1'b0));
    endtask

    task automatic test_register_settings();
        // widest window, zero threshold makes any read rail present
        apply_settings('0, '0, MV_MAX);
        send_item(make_sample(16'd0, 1'b1, 16'd0, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_sample(MV_MAX, 1'b1, 16'd0, 1'b0, MV_MAX, 1'b0, 1'b1, 1'b1));
        // window of a single voltage, threshold at full scale
        apply_settings(MV_MAX, 16'd3900, 16'd3900);
        send_item(make_sample(16'd3900, 1'b1, MV_MAX, 1'b1, MV_MAX - 16'd1, 1'b1,
                              1'b0, 1'b0));
        send_item(make_sample(16'd3901, 1'b1, MV_MAX - 16'd1, 1'b1, MV_MAX, 1'b1,
                              1'b0, 1'b0));
        // min above max
        apply_settings(16'd4000, 16'd4001, 16'd4000);
        send_item(make_sample(16'd4000, 1'b1, 16'd5000, 1'b1, 16'd5000, 1'b1, 1'b1, 1'b1));
        // a write past the last register must leave the defaults alone
        apply_settings(bpse_pkg::RST_USB_THRESHOLD_MV, bpse_pkg::RST_BATTERY_MIN_MV,
                       bpse_pkg::RST_BATTERY_MAX_MV);
        write_reg(CFG_UNUSED_IDX, '0);
        send_item(make_sample(16'd3800, 1'b1, 16'd100, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            randomize_settings();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // let the pipeline run dry now and then
                if (n > 0 && n % DRAIN_EVERY == 0)
                    drain_results();
                send_item(rand_sample());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = bpse_pkg::CFG_USB_THRESHOLD;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_cnt   = 0;
        thr_mv         = bpse_pkg::RST_USB_THRESHOLD_MV;
        win_min_mv     = bpse_pkg::RST_BATTERY_MIN_MV;
        win_max_mv     = bpse_pkg::RST_BATTERY_MAX_MV;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_default_curve();
        test_register_settings();
        test_random_traffic();
        drain_results();

        if (mismatch_cnt == 0 && pending_status_q.size() == 0)
            $display("battery_power_status_evaluator_top_tb: clean");
        else
            $display("battery_power_status_evaluator_top_tb: errors");
        $finish;
    end

endmodule
